FILE: hw/rtl/gsuf_pkg.sv
// Package for the graph segment union-find core: widths, state encoding.
// No dependencies.
package gsuf_pkg;
	localparam int NODE_BITS   = 16;
	localparam int NUM_NODES   = 1 << NODE_BITS;
	localparam int WEIGHT_BITS = 16;
	localparam int SIZE_BITS   = 17;
	localparam int K_BITS      = 16;
	localparam logic [K_BITS-1:0] K_RESET = 16'd1200;
	// set entry: size and max weight stored together
	localparam int SET_BITS = SIZE_BITS + WEIGHT_BITS;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_WT,
		ST_FIND_CHK,
		ST_COMP_RD,
		ST_COMP_WT,
		ST_COMP_WR,
		ST_SET_RD,
		ST_SET_WT,
		ST_SET_LATCH,
		ST_TOL_A,
		ST_TOL_B,
		ST_TOL_CHK,
		ST_MERGE,
		ST_OUT
	} state_t;
endpackage

FILE: hw/rtl/gsuf_if.sv
// Valid/ready channel interfaces for the union-find core.
// Depends on gsuf_pkg.
interface gsuf_edge_if;
	logic                                valid;
	logic                                ready;
	logic [gsuf_pkg::NODE_BITS-1:0]      node_a;
	logic [gsuf_pkg::NODE_BITS-1:0]      node_b;
	logic [gsuf_pkg::WEIGHT_BITS-1:0]    edge_weight;
	modport source (output valid, node_a, node_b, edge_weight, input ready);
	modport sink   (input valid, node_a, node_b, edge_weight, output ready);
endinterface

interface gsuf_result_if;
	logic                                valid;
	logic                                ready;
	logic                                accepted;
	logic                                same_set;
	logic [gsuf_pkg::NODE_BITS-1:0]      result_root;
	logic [gsuf_pkg::SIZE_BITS-1:0]      result_size;
	logic [gsuf_pkg::WEIGHT_BITS-1:0]    result_max_weight;
	modport source (output valid, accepted, same_set, result_root, result_size,
		result_max_weight, input ready);
	modport sink   (input valid, accepted, same_set, result_root, result_size,
		result_max_weight, output ready);
endinterface

interface gsuf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [gsuf_pkg::K_BITS-1:0]    data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/gsuf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module gsuf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: hw/rtl/gsuf_tol_mul.sv
// Shared tolerance check: (w - max) * size compared with k, result registered.
// Depends on gsuf_pkg.
module gsuf_tol_mul (
	input  logic                              clk,
	input  logic [gsuf_pkg::WEIGHT_BITS-1:0]  w,
	input  logic [gsuf_pkg::WEIGHT_BITS-1:0]  max_w,
	input  logic [gsuf_pkg::SIZE_BITS-1:0]    size,
	input  logic [gsuf_pkg::K_BITS-1:0]       k,
	output logic                              ok_q
);
	localparam int PBITS = gsuf_pkg::WEIGHT_BITS + gsuf_pkg::SIZE_BITS;
	logic [gsuf_pkg::WEIGHT_BITS-1:0] diff;
	logic [PBITS-1:0]                 prod;

	// form the excess over max and scale it by the set size
	always_comb begin
		diff = w - max_w;
		prod = PBITS'(diff) * PBITS'(size);
	end

	always_ff @(posedge clk) begin
		ok_q <= (w <= max_w) || (prod <= PBITS'(k));
	end
endmodule

FILE: hw/rtl/graph_segment_union_find_core.sv
// Top level of the union-find segmentation core: sequencer, tables, result.
// Depends on gsuf_pkg, gsuf_if, gsuf_ram, gsuf_tol_mul.
//
// Channel | Dir | Payload
// edge_in | in  | node_a, node_b, edge_weight
// res_out | out | accepted, same_set, result_root, result_size, result_max_weight
// cfg     | in  | data (merge_constant)
//
// Sequence: one idle state takes the edge. Each root walk reads, waits on and
// checks every node visited, root included, then reads, waits on and rewrites
// every non-root node in compression before it finishes. Set reads, the tolerance
// test, the merge and the result follow; the single-port RAMs set this order.
// Reset: a clearing pass writes every entry of both tables; no edge is
// taken meanwhile. A stalled result holds the core until it is taken.
module graph_segment_union_find_core (
	input  logic clk,
	input  logic arst_n,
	gsuf_edge_if.sink     edge_in,
	gsuf_result_if.source res_out,
	gsuf_cfg_if.sink      cfg
);
	localparam int NB = gsuf_pkg::NODE_BITS;
	localparam int WB = gsuf_pkg::WEIGHT_BITS;
	localparam int SB = gsuf_pkg::SIZE_BITS;

	gsuf_pkg::state_t state_q, state_d;

	logic [NB-1:0] b_q, node_q, cur_q, root_q, ra_q, rb_q, clr_q;
	logic [WB-1:0] w_q, ma_q, mb_q;
	logic [SB-1:0] sa_q, sb_q;
	logic [gsuf_pkg::K_BITS-1:0] k_q;
	logic          side_q;   // 0: walking node_a, 1: node_b
	logic          acc_q, same_q, tol_a_q;
	logic [WB-1:0] mx_merge;

	// RAM ports
	logic          p_we, s_we;
	logic [NB-1:0] p_addr, s_addr, p_wdata, p_rdata;
	logic [gsuf_pkg::SET_BITS-1:0] s_wdata, s_rdata;

	gsuf_ram #(.WIDTH(NB), .DEPTH(gsuf_pkg::NUM_NODES)) u_parent (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));
	gsuf_ram #(.WIDTH(gsuf_pkg::SET_BITS), .DEPTH(gsuf_pkg::NUM_NODES)) u_set (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));

	// shared multiplier, operands picked by the sequencer
	logic          tol_ok_q;
	logic          tol_sel;
	gsuf_tol_mul u_mul (
		.clk(clk), .w(w_q),
		.max_w(tol_sel ? mb_q : ma_q),
		.size(tol_sel ? sb_q : sa_q),
		.k(k_q), .ok_q(tol_ok_q));

	assign edge_in.ready = (state_q == gsuf_pkg::ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign res_out.valid = (state_q == gsuf_pkg::ST_OUT);
	assign res_out.accepted          = acc_q;
	assign res_out.same_set          = same_q;
	assign res_out.result_root       = rb_q;
	assign res_out.result_size       = sb_q;
	assign res_out.result_max_weight = mb_q;

	// largest of both set maxima and the edge weight
	always_comb begin
		mx_merge = (ma_q > mb_q) ? ma_q : mb_q;
		if (w_q > mx_merge) begin
			mx_merge = w_q;
		end
	end

	// next state and RAM controls
	always_comb begin
		state_d = state_q;
		p_we    = 1'b0;
		s_we    = 1'b0;
		p_addr  = cur_q;
		p_wdata = root_q;
		s_addr  = ra_q;
		s_wdata = {sb_q, mb_q};
		tol_sel = 1'b0;
		unique case (state_q)
			gsuf_pkg::ST_CLEAR: begin
				p_we    = 1'b1;
				s_we    = 1'b1;
				p_addr  = clr_q;
				s_addr  = clr_q;
				p_wdata = clr_q;
				s_wdata = {SB'(1), WB'(0)};
				if (clr_q == '1) begin
					state_d = gsuf_pkg::ST_IDLE;
				end
			end
			gsuf_pkg::ST_IDLE: begin
				if (edge_in.valid) begin
					state_d = gsuf_pkg::ST_FIND_RD;
				end
			end
			gsuf_pkg::ST_FIND_RD:  state_d = gsuf_pkg::ST_FIND_WT;
			gsuf_pkg::ST_FIND_WT:  state_d = gsuf_pkg::ST_FIND_CHK;
			gsuf_pkg::ST_FIND_CHK: begin
				if (p_rdata == cur_q) begin
					state_d = gsuf_pkg::ST_COMP_RD;
				end else begin
					state_d = gsuf_pkg::ST_FIND_RD;
				end
			end
			gsuf_pkg::ST_COMP_RD: begin
				if (cur_q == root_q) begin
					state_d = (side_q) ? gsuf_pkg::ST_SET_RD : gsuf_pkg::ST_FIND_RD;
				end else begin
					state_d = gsuf_pkg::ST_COMP_WT;
				end
			end
			gsuf_pkg::ST_COMP_WT: state_d = gsuf_pkg::ST_COMP_WR;
			gsuf_pkg::ST_COMP_WR: begin
				p_we    = 1'b1;
				state_d = gsuf_pkg::ST_COMP_RD;
			end
			gsuf_pkg::ST_SET_RD: begin
				s_addr  = ra_q;
				state_d = gsuf_pkg::ST_SET_WT;
			end
			gsuf_pkg::ST_SET_WT: begin
				s_addr  = ra_q;
				state_d = gsuf_pkg::ST_SET_LATCH;
			end
			gsuf_pkg::ST_SET_LATCH: begin
				s_addr  = rb_q;
				state_d = gsuf_pkg::ST_TOL_A;
			end
			gsuf_pkg::ST_TOL_A: state_d = gsuf_pkg::ST_TOL_B;
			gsuf_pkg::ST_TOL_B: begin
				tol_sel = 1'b1;
				state_d = gsuf_pkg::ST_TOL_CHK;
			end
			gsuf_pkg::ST_TOL_CHK: state_d = gsuf_pkg::ST_MERGE;
			gsuf_pkg::ST_MERGE: begin
				// when accepted, hang root a under root b and write the merged set
				if (acc_q) begin
					p_we    = 1'b1;
					p_addr  = ra_q;
					p_wdata = rb_q;
					s_we    = 1'b1;
					s_addr  = rb_q;
					s_wdata = {sb_q + sa_q, mx_merge};
				end
				state_d = gsuf_pkg::ST_OUT;
			end
			gsuf_pkg::ST_OUT: begin
				if (res_out.ready) begin
					state_d = gsuf_pkg::ST_IDLE;
				end
			end
			default: state_d = gsuf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsuf_pkg::ST_CLEAR;
			clr_q   <= '0;
			k_q     <= gsuf_pkg::K_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == gsuf_pkg::ST_CLEAR) begin
				clr_q <= clr_q + NB'(1);
			end
			if (cfg.valid) begin
				k_q <= cfg.data;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			gsuf_pkg::ST_IDLE: begin
				b_q    <= edge_in.node_b;
				w_q    <= edge_in.edge_weight;
				cur_q  <= edge_in.node_a;
				node_q <= edge_in.node_a;
				side_q <= 1'b0;
			end
			gsuf_pkg::ST_FIND_CHK: begin
				// advance up the chain, or note the root and restart at the leaf
				if (p_rdata == cur_q) begin
					root_q <= cur_q;
					cur_q  <= node_q;
				end else begin
					cur_q <= p_rdata;
				end
			end
			gsuf_pkg::ST_COMP_RD: begin
				if (cur_q == root_q) begin
					if (side_q) begin
						rb_q <= root_q;
					end else begin
						ra_q   <= root_q;
						side_q <= 1'b1;
						cur_q  <= b_q;
						node_q <= b_q;
					end
				end
			end
			gsuf_pkg::ST_COMP_WR: cur_q <= p_rdata;
			gsuf_pkg::ST_SET_LATCH: begin
				sa_q <= s_rdata[gsuf_pkg::SET_BITS-1:WB];
				ma_q <= s_rdata[WB-1:0];
			end
			gsuf_pkg::ST_TOL_A: begin
				sb_q <= s_rdata[gsuf_pkg::SET_BITS-1:WB];
				mb_q <= s_rdata[WB-1:0];
			end
			gsuf_pkg::ST_TOL_B: tol_a_q <= tol_ok_q;
			gsuf_pkg::ST_TOL_CHK: begin
				same_q <= (ra_q == rb_q);
				acc_q  <= (ra_q != rb_q) && tol_a_q && tol_ok_q;
			end
			gsuf_pkg::ST_MERGE: begin
				if (acc_q) begin
					sb_q <= sb_q + sa_q;
					mb_q <= mx_merge;
				end
			end
			default: ;
		endcase
	end

	// checks
	ap_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> !edge_in.ready) else $error("ready while result pending");
	ap_acc_not_same: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> !(res_out.accepted && res_out.same_set))
		else $error("accepted and same_set both set");
	ap_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.result_root))
		else $error("result dropped while stalled");
endmodule
